// ===== hw/rtl/blf_pkg.sv =====
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types and constants of the battery level filter.
// ----------------------------------------------------------------------------
package blf_pkg;

    localparam int WINDOW_LEN_DEF  = 5;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int IN_BITS    = 12;
    localparam int COUNT_BITS = 12;
    localparam int PCT_BITS   = 7;
    localparam int ALPHA_W    = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [4:0]  DIV_TEN   = 5'd10;
    localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_BITS-1:0] PCT_NONE = 7'd0;

    localparam logic [31:0] GAIN_RST  = 32'd105600;
    localparam logic [16:0] ALPHA_RST = 17'd6554;
    localparam logic [15:0] EMPTY_RST = 16'd3300;
    localparam logic [15:0] FULL_RST  = 16'd4200;

    typedef logic [CFG_INDEX_W-1:0] blf_cfg_index_t;

    localparam blf_cfg_index_t REG_GAIN  = 2'd0;
    localparam blf_cfg_index_t REG_ALPHA = 2'd1;
    localparam blf_cfg_index_t REG_EMPTY = 2'd2;
    localparam blf_cfg_index_t REG_FULL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_AVG,
        ST_DIV10,
        ST_SCALE,
        ST_VSET,
        ST_MIX,
        ST_VSUM,
        ST_PCHECK,
        ST_PLOAD,
        ST_PDIV,
        ST_OUT
    } blf_state_t;

endpackage

// ===== hw/rtl/battery_level_filter_unit.sv =====
// ----------------------------------------------------------------------------
// battery_level_filter_unit
// Median-of-window and two moving averages that turn raw battery ADC
// samples into a filtered count and a charge percent.
//
// Usage: samples arrive as transfers on the s_ channel (s_valid/s_ready).
// Each sample gives exactly one result transfer on the m_ channel carrying
// m_filtered_count and m_percent. Registers are written through the cfg_
// channel (cfg_index, cfg_data), which is always ready; write them only
// while no sample is in flight.
// One sample is processed at a time. The median search, the divide by
// ten, the gain multiply, the alpha multiply and the percent divide run in
// turn, the last four bit serial. The first sample skips the divide by ten,
// and samples outside the percent range skip the percent divide.
// The result sits in an output register; s_ready returns while it waits,
// and a finished next result holds until the receiver takes the first.
// Reset clears the sample window, both averages and the registers to their
// default values.
// ----------------------------------------------------------------------------
module battery_level_filter_unit
    import blf_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [IN_BITS-1:0]     s_adc_sample,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_BITS-1:0]  m_filtered_count,
    output logic [PCT_BITS-1:0]    m_percent,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  blf_cfg_index_t         cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W   = $clog2(WINDOW_LEN);
    localparam int RANK_W  = $clog2(WINDOW_LEN + 1);
    localparam int NUM_W   = SAMPLE_BITS + 4;
    localparam int OP_W    = (SAMPLE_BITS > ALPHA_W) ? SAMPLE_BITS : ALPHA_W;
    localparam int CNT_MAX = (NUM_W > ALPHA_W) ? NUM_W : ALPHA_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int ACC_W   = (SAMPLE_BITS + 33 > 51) ? SAMPLE_BITS + 33 : 51;
    localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(WINDOW_LEN / 2);

    blf_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW_LEN];
    logic [PTR_W-1:0]       pos_reg;
    logic [PTR_W-1:0]       wr_pos;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] med_reg, med_next;
    logic [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                   seeded_reg, seeded_next;
    logic [NUM_W-1:0]       div_reg, div_next;
    logic [3:0]             r10_reg, r10_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]            v_reg, v_next;
    logic [31:0]            va_reg, va_next;
    logic signed [32:0]     d_reg, d_next;
    logic [38:0]            prem_reg, prem_next;
    logic [37:0]            den_reg, den_next;
    logic [PCT_BITS-1:0]    pct_reg, pct_next;

    logic [31:0]            gain_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [15:0]            empty_reg;
    logic [15:0]            full_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0]  m_count_reg, m_count_next;
    logic [PCT_BITS-1:0]    m_pct_reg, m_pct_next;

    logic                   in_xfer;
    logic                   out_free;
    logic                   last_med, last_div, last_scale, last_mix, last_pct;

    logic [SAMPLE_BITS-1:0] cand;
    logic [WINDOW_LEN-1:0]  below;
    logic [RANK_W-1:0]      rank;

    logic [4:0]             r10_shift;
    logic                   r10_ge;
    logic [NUM_W-1:0]       div_step;
    logic signed [ACC_W-1:0] gain_ext, d_ext, acc_shl;
    logic [31:0]            v_sat;
    logic [31:0]            va_eff;
    logic [ALPHA_W-1:0]     alpha_eff;
    logic signed [ACC_W-1:0] acc_sra;
    logic [32:0]            va_sum;

    logic [31:0]            pct_lo;
    logic [15:0]            span16;
    logic [31:0]            pct_span;
    logic [31:0]            pct_diff;
    logic                   pct_zero, pct_top;
    logic                   p_ge;

    assign in_xfer   = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_filtered_count = m_count_reg;
    assign m_percent        = m_pct_reg;

    assign wr_pos = ({1'b0, pos_reg} >= (PTR_W + 1)'(WINDOW_LEN)) ? '0 : pos_reg;

    assign last_med   = (cnt_reg == CNT_W'(WINDOW_LEN - 1));
    assign last_div   = (cnt_reg == CNT_W'(NUM_W - 1));
    assign last_scale = (cnt_reg == CNT_W'(SAMPLE_BITS - 1));
    assign last_mix   = (cnt_reg == CNT_W'(ALPHA_W - 1));
    assign last_pct   = (cnt_reg == CNT_W'(PCT_BITS - 1));

    assign cand = ring_reg[cnt_reg[PTR_W-1:0]];

    always_comb begin
        for (int j = 0; j < WINDOW_LEN; j++) begin
            below[j] = (ring_reg[j] < cand) ||
                       ((ring_reg[j] == cand) && (PTR_W'(j) < cnt_reg[PTR_W-1:0]));
        end
        rank = RANK_W'($countones(below));
    end

    assign r10_shift = {r10_reg, div_reg[NUM_W-1]};
    assign r10_ge    = (r10_shift >= DIV_TEN);
    assign div_step  = {div_reg[NUM_W-2:0], r10_ge};

    assign gain_ext = $signed({{(ACC_W - 32){1'b0}}, gain_reg});
    assign d_ext    = $signed({{(ACC_W - 33){d_reg[32]}}, d_reg});
    assign acc_shl  = acc_reg <<< 1;
    assign v_sat    = (acc_next[ACC_W-1:32] != '0) ? '1 : acc_next[31:0];
    assign va_eff   = (va_reg == '0) ? v_reg : va_reg;
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign acc_sra  = acc_reg >>> 16;
    assign va_sum   = {1'b0, va_reg} + acc_sra[32:0];

    assign pct_lo   = {empty_reg, 16'h0000};
    assign span16   = full_reg - empty_reg;
    assign pct_span = {span16, 16'h0000};
    assign pct_diff = va_reg - pct_lo;
    assign pct_zero = (full_reg <= empty_reg) || (va_reg <= pct_lo);
    assign pct_top  = (pct_diff >= pct_span);
    assign p_ge     = (prem_reg >= {1'b0, den_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_MEDIAN;
            ST_MEDIAN: if (last_med) state_next = ST_AVG;
            ST_AVG:    state_next = seeded_reg ? ST_DIV10 : ST_SCALE;
            ST_DIV10:  if (last_div) state_next = ST_SCALE;
            ST_SCALE:  if (last_scale) state_next = ST_VSET;
            ST_VSET:   state_next = ST_MIX;
            ST_MIX:    if (last_mix) state_next = ST_VSUM;
            ST_VSUM:   state_next = ST_PCHECK;
            ST_PCHECK: state_next = (pct_zero || pct_top) ? ST_OUT : ST_PLOAD;
            ST_PLOAD:  state_next = ST_PDIV;
            ST_PDIV:   if (last_pct) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next     = '0;
        med_next     = med_reg;
        avg_next     = avg_reg;
        seeded_next  = seeded_reg;
        div_next     = div_reg;
        r10_next     = r10_reg;
        op_next      = op_reg;
        acc_next     = acc_reg;
        v_next       = v_reg;
        va_next      = va_reg;
        d_next       = d_reg;
        prem_next    = prem_reg;
        den_next     = den_reg;
        pct_next     = pct_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_count_next = m_count_reg;
        m_pct_next   = m_pct_reg;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_MEDIAN: begin
                cnt_next = last_med ? '0 : cnt_reg + 1'b1;
                if (rank == MED_RANK) begin
                    med_next = cand;
                end
            end
            ST_AVG: begin
                acc_next = '0;
                if (seeded_reg) begin
                    div_next = NUM_W'(med_reg) + (NUM_W'(avg_reg) << 3) + NUM_W'(avg_reg);
                    r10_next = '0;
                end else begin
                    avg_next    = med_reg;
                    seeded_next = 1'b1;
                    op_next     = OP_W'(med_reg) << (OP_W - SAMPLE_BITS);
                end
            end
            ST_DIV10: begin
                cnt_next = last_div ? '0 : cnt_reg + 1'b1;
                r10_next = r10_ge ? 4'(r10_shift - DIV_TEN) : r10_shift[3:0];
                div_next = div_step;
                if (last_div) begin
                    avg_next = div_step[SAMPLE_BITS-1:0];
                    op_next  = OP_W'(div_step[SAMPLE_BITS-1:0]) << (OP_W - SAMPLE_BITS);
                end
            end
            ST_SCALE: begin
                cnt_next = last_scale ? '0 : cnt_reg + 1'b1;
                acc_next = acc_shl + (op_reg[OP_W-1] ? gain_ext : '0);
                op_next  = op_reg << 1;
                if (last_scale) begin
                    v_next = v_sat;
                end
            end
            ST_VSET: begin
                va_next  = va_eff;
                d_next   = $signed({1'b0, v_reg}) - $signed({1'b0, va_eff});
                op_next  = OP_W'(alpha_eff) << (OP_W - ALPHA_W);
                acc_next = '0;
            end
            ST_MIX: begin
                cnt_next = last_mix ? '0 : cnt_reg + 1'b1;
                acc_next = acc_shl + (op_reg[OP_W-1] ? d_ext : '0);
                op_next  = op_reg << 1;
            end
            ST_VSUM: begin
                va_next = va_sum[31:0];
            end
            ST_PCHECK: begin
                prem_next = 39'(pct_diff);
                den_next  = {pct_span, 6'b000000};
                if (pct_zero) begin
                    pct_next = PCT_NONE;
                end else if (pct_top) begin
                    pct_next = PCT_FULL;
                end
            end
            ST_PLOAD: begin
                prem_next = (prem_reg << 6) + (prem_reg << 5) + (prem_reg << 2);
            end
            ST_PDIV: begin
                cnt_next  = last_pct ? '0 : cnt_reg + 1'b1;
                prem_next = p_ge ? prem_reg - {1'b0, den_reg} : prem_reg;
                den_next  = den_reg >> 1;
                pct_next  = {pct_reg[PCT_BITS-2:0], p_ge};
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = COUNT_BITS'(avg_reg);
                    m_pct_next   = pct_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            seeded_reg  <= 1'b0;
            avg_reg     <= '0;
            va_reg      <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            gain_reg    <= GAIN_RST;
            alpha_reg   <= ALPHA_RST;
            empty_reg   <= EMPTY_RST;
            full_reg    <= FULL_RST;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            seeded_reg  <= seeded_next;
            avg_reg     <= avg_next;
            va_reg      <= va_next;
            m_valid_reg <= m_valid_next;
            if (in_xfer) begin
                ring_reg[wr_pos] <= SAMPLE_BITS'(s_adc_sample);
                pos_reg <= (wr_pos == PTR_W'(WINDOW_LEN - 1)) ? '0 : wr_pos + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_GAIN:  gain_reg  <= cfg_data;
                    REG_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                    REG_EMPTY: empty_reg <= cfg_data[15:0];
                    REG_FULL:  full_reg  <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        med_reg     <= med_next;
        div_reg     <= div_next;
        r10_reg     <= r10_next;
        op_reg      <= op_next;
        acc_reg     <= acc_next;
        v_reg       <= v_next;
        d_reg       <= d_next;
        prem_reg    <= prem_next;
        den_reg     <= den_next;
        pct_reg     <= pct_next;
        m_count_reg <= m_count_next;
        m_pct_reg   <= m_pct_next;
    end

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_percent <= PCT_FULL))
        else $error("percent result above full scale");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample taken while one is in flight");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pos_reg} < (PTR_W + 1)'(WINDOW_LEN))
        else $error("window position out of range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

endmodule
